@@ hw/rtl/bounded_array_list_engine_assert.svh @@
// assertion macros shared by the checker of the bounded array list engine
// needs a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef BOUNDED_ARRAY_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define BALE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define BALE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/bale_pkg.sv @@
// shared types and constants of the bounded array list engine
// no dependencies
package bale_pkg;

    // field widths
    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int ID_W     = 32;
    localparam int AGE_W    = 8;
    localparam int ST_W     = 3;
    localparam int FPOS_W   = 4;
    localparam int OAGE_W   = 9;
    localparam int LCNT_W   = 5;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 56;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOCATE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RETRIEVE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SORTED   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd5;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_PUT,
        S_FETCH,
        S_FETCH_WAIT,
        S_DONE
    } t_state;

    // compare unit request and result
    typedef struct packed {
        logic [ID_W-1:0] stored_id;
        logic [ID_W-1:0] key;
        logic            by_order;
    } t_cmp_req;

    typedef struct packed {
        logic eq;
        logic lt;
        logic hit;
    } t_cmp_res;

endpackage

@@ hw/rtl/bale_cmp.sv @@
// shared id compare unit: equality, signed less-than and the scan hit
// depends on bale_pkg
module bale_cmp (
    input  bale_pkg::t_cmp_req i_req,
    output bale_pkg::t_cmp_res o_res
);

    // locate stops on an equal id, sorted insert on the first id not below the key
    always_comb begin
        o_res.eq  = (i_req.stored_id == i_req.key);
        o_res.lt  = ($signed(i_req.stored_id) < $signed(i_req.key));
        o_res.hit = i_req.by_order ? !o_res.lt : o_res.eq;
    end

endmodule

@@ hw/rtl/bounded_array_list_engine.sv @@
// Bounded array list engine.
// Input stream: one request per item, tuser carries the command, tdata the position, id
// and age. Output stream: exactly one result per request with status, locate position,
// retrieved id and age, and the entry count after the operation.
// A request is taken only while the sequencer is idle; o_s_axis_tready drops for the
// whole operation. Entries live in a single-port-write, registered-read memory; every
// walk goes one entry per cycle through it, and scans also use the shared compare unit.
// The memory takes one read and one write per cycle.
// Reset empties the list (count zero, nothing pending); memory contents are not cleared.
// A finished result waits in the output register while the receiver stalls; the next
// request can be taken and worked on meanwhile, and only its own completion waits for
// the output register to free up.
// depends on bale_pkg and bale_cmp
module bounded_array_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata from bit 0: position[4:0], entry_id[36:5], entry_age[44:37], zero pad
    input  logic [bale_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    // tuser: cmd[2:0]
    input  logic [bale_pkg::CMD_W-1:0]    i_s_axis_tuser,
    // result stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // tdata from bit 0: status[2:0], found_position[6:3], out_id[38:7],
    // out_age[47:39], list_count[52:48], zero pad
    output logic [bale_pkg::M_DATA_W-1:0] o_m_axis_tdata
);

    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMPW     = (CW > bale_pkg::POS_W) ? CW : bale_pkg::POS_W;
    localparam int EW       = bale_pkg::ID_W + bale_pkg::AGE_W;
    localparam int ID_LO    = bale_pkg::POS_W;
    localparam int AGE_LO   = ID_LO + bale_pkg::ID_W;
    localparam int M_USED_W = bale_pkg::ST_W + bale_pkg::FPOS_W + bale_pkg::ID_W
                              + bale_pkg::OAGE_W + bale_pkg::LCNT_W;
    localparam logic [CMPW-1:0] CAP_EXT = CMPW'(CAPACITY);

    // control state
    bale_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic             r_pend, n_pend;
    logic             r_out_valid, n_out_valid;

    // request and walk registers
    logic [bale_pkg::CMD_W-1:0]  r_cmd, n_cmd;
    logic [CMPW-1:0]             r_pos, n_pos;
    logic [bale_pkg::ID_W-1:0]   r_key, n_key;
    logic [bale_pkg::AGE_W-1:0]  r_age, n_age;
    logic [CW-1:0]               r_idx, n_idx;
    logic [CW-1:0]               r_left, n_left;
    logic [CW-1:0]               r_wa, n_wa;
    logic [CW-1:0]               r_tgt, n_tgt;

    // result and output registers
    logic [bale_pkg::ST_W-1:0]   r_st, n_st;
    logic [bale_pkg::FPOS_W-1:0] r_fp, n_fp;
    logic [bale_pkg::ID_W-1:0]   r_oid, n_oid;
    logic [bale_pkg::OAGE_W-1:0] r_oage, n_oage;
    logic [bale_pkg::M_DATA_W-1:0] r_out_data, n_out_data;

    // entry memory
    logic [EW-1:0] mem [CAPACITY];
    logic [EW-1:0] r_rd_data;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    // request fields
    logic [bale_pkg::CMD_W-1:0] in_cmd;
    logic [CMPW-1:0]            in_pos_ext;
    logic [CW-1:0]              in_pos_cw;
    logic [CMPW-1:0]            cnt_ext;
    logic                       in_take;

    bale_pkg::t_cmp_req cmp_req;
    bale_pkg::t_cmp_res cmp_res;

    assign in_cmd     = i_s_axis_tuser;
    assign in_pos_ext = CMPW'(i_s_axis_tdata[bale_pkg::POS_W-1:0]);
    assign in_pos_cw  = in_pos_ext[CW-1:0];
    assign cnt_ext    = CMPW'(r_count);
    assign in_take    = i_s_axis_tvalid && (r_state == bale_pkg::S_IDLE);

    assign o_s_axis_tready = (r_state == bale_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // shared compare unit against the entry just read
    assign cmp_req.stored_id = r_rd_data[EW-1:bale_pkg::AGE_W];
    assign cmp_req.key       = r_key;
    assign cmp_req.by_order  = (r_cmd == bale_pkg::CMD_SORTED);

    bale_cmp u_cmp (
        .i_req (cmp_req),
        .o_res (cmp_res)
    );

    // sequencer next state and memory controls
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_cmd       = r_cmd;
        n_pos       = r_pos;
        n_key       = r_key;
        n_age       = r_age;
        n_idx       = r_idx;
        n_left      = r_left;
        n_wa        = r_wa;
        n_tgt       = r_tgt;
        n_st        = r_st;
        n_fp        = r_fp;
        n_oid       = r_oid;
        n_oage      = r_oage;
        n_out_data  = r_out_data;
        rd_en       = 1'b0;
        rd_addr     = r_idx[IW-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_wa[IW-1:0];
        wr_data     = r_rd_data;

        // receiver takes the waiting result
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            bale_pkg::S_IDLE: begin
                if (in_take) begin
                    n_cmd  = in_cmd;
                    n_pos  = in_pos_ext;
                    n_key  = i_s_axis_tdata[AGE_LO-1:ID_LO];
                    n_age  = i_s_axis_tdata[AGE_LO+bale_pkg::AGE_W-1:AGE_LO];
                    n_st   = bale_pkg::ST_OK;
                    n_fp   = '0;
                    n_oid  = '0;
                    n_oage = '0;
                    n_pend = 1'b0;
                    n_idx  = '0;
                    n_state = bale_pkg::S_DONE;
                    case (in_cmd)
                        bale_pkg::CMD_INSERT: begin
                            if (cnt_ext >= CAP_EXT) begin
                                n_st = bale_pkg::ST_FULL;
                            end else if (in_pos_ext > cnt_ext) begin
                                n_st = bale_pkg::ST_BADPOS;
                            end else begin
                                n_tgt   = in_pos_cw;
                                n_idx   = r_count - CW'(1);
                                n_left  = r_count - in_pos_cw;
                                n_state = bale_pkg::S_SHIFT_UP;
                            end
                        end
                        bale_pkg::CMD_DELETE: begin
                            if (r_count == '0) begin
                                n_st = bale_pkg::ST_EMPTY;
                            end else if (in_pos_ext >= cnt_ext) begin
                                n_st = bale_pkg::ST_BADPOS;
                            end else begin
                                n_idx   = in_pos_cw + CW'(1);
                                n_left  = r_count - in_pos_cw - CW'(1);
                                n_state = bale_pkg::S_SHIFT_DN;
                            end
                        end
                        bale_pkg::CMD_LOCATE: begin
                            n_state = bale_pkg::S_SCAN;
                        end
                        bale_pkg::CMD_RETRIEVE: begin
                            if (in_pos_ext >= cnt_ext) begin
                                n_st   = bale_pkg::ST_BADPOS;
                                n_oid  = '1;
                                n_oage = '1;
                            end else begin
                                n_state = bale_pkg::S_FETCH;
                            end
                        end
                        bale_pkg::CMD_SORTED: begin
                            if (cnt_ext >= CAP_EXT) begin
                                n_st = bale_pkg::ST_FULL;
                            end else begin
                                n_state = bale_pkg::S_SCAN;
                            end
                        end
                        bale_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // one read per cycle, hit checked on the data of the previous read
            bale_pkg::S_SCAN: begin
                if (r_pend && cmp_res.hit) begin
                    n_pend = 1'b0;
                    if (r_cmd == bale_pkg::CMD_SORTED) begin
                        n_tgt   = r_wa;
                        n_idx   = r_count - CW'(1);
                        n_left  = r_count - r_wa;
                        n_state = bale_pkg::S_SHIFT_UP;
                    end else begin
                        n_fp    = bale_pkg::FPOS_W'(r_wa);
                        n_state = bale_pkg::S_DONE;
                    end
                end else if (!r_pend && (r_idx >= r_count)) begin
                    if (r_cmd == bale_pkg::CMD_SORTED) begin
                        n_tgt   = r_count;
                        n_state = bale_pkg::S_PUT;
                    end else begin
                        n_st    = bale_pkg::ST_NOTFOUND;
                        n_state = bale_pkg::S_DONE;
                    end
                end else if (r_idx < r_count) begin
                    rd_en  = 1'b1;
                    n_wa   = r_idx;
                    n_idx  = r_idx + CW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end

            // move entries one place up, from the tail down to the target
            bale_pkg::S_SHIFT_UP: begin
                wr_en = r_pend;
                if (r_left != '0) begin
                    rd_en  = 1'b1;
                    n_wa   = r_idx + CW'(1);
                    n_idx  = r_idx - CW'(1);
                    n_left = r_left - CW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = bale_pkg::S_PUT;
                    end
                end
            end

            // move entries one place down, from behind the position to the tail
            bale_pkg::S_SHIFT_DN: begin
                wr_en = r_pend;
                if (r_left != '0) begin
                    rd_en  = 1'b1;
                    n_wa   = r_idx - CW'(1);
                    n_idx  = r_idx + CW'(1);
                    n_left = r_left - CW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count = r_count - CW'(1);
                        n_state = bale_pkg::S_DONE;
                    end
                end
            end

            // write the new entry into the opened slot
            bale_pkg::S_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_tgt[IW-1:0];
                wr_data = {r_key, r_age};
                n_count = r_count + CW'(1);
                n_state = bale_pkg::S_DONE;
            end

            bale_pkg::S_FETCH: begin
                rd_en   = 1'b1;
                rd_addr = r_pos[IW-1:0];
                n_state = bale_pkg::S_FETCH_WAIT;
            end

            bale_pkg::S_FETCH_WAIT: begin
                n_oid   = r_rd_data[EW-1:bale_pkg::AGE_W];
                n_oage  = {1'b0, r_rd_data[bale_pkg::AGE_W-1:0]};
                n_state = bale_pkg::S_DONE;
            end

            // hand the result over once the output register is free
            bale_pkg::S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{(bale_pkg::M_DATA_W-M_USED_W){1'b0}},
                                   bale_pkg::LCNT_W'(r_count), r_oage, r_oid, r_fp, r_st};
                    n_state     = bale_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bale_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bale_pkg::S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_pos      <= n_pos;
        r_key      <= n_key;
        r_age      <= n_age;
        r_idx      <= n_idx;
        r_left     <= n_left;
        r_wa       <= n_wa;
        r_tgt      <= n_tgt;
        r_st       <= n_st;
        r_fp       <= n_fp;
        r_oid      <= n_oid;
        r_oage     <= n_oage;
        r_out_data <= n_out_data;
    end

    // entry memory write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // entry memory registered read port
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/bale_chk.sv @@
// port-level checker of the bounded array list engine, bound to the top level
// depends on bale_pkg and bounded_array_list_engine_assert.svh
`include "bounded_array_list_engine_assert.svh"

module bale_chk #(
    parameter int CAPACITY = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [bale_pkg::M_DATA_W-1:0] o_m_axis_tdata
);

    logic [bale_pkg::ST_W-1:0]   res_status;
    logic [bale_pkg::FPOS_W-1:0] res_fpos;
    logic [bale_pkg::LCNT_W-1:0] res_count;

    assign res_status = o_m_axis_tdata[2:0];
    assign res_fpos   = o_m_axis_tdata[6:3];
    assign res_count  = o_m_axis_tdata[52:48];

    // a waiting result holds until taken
    `BALE_ASSERT_NEXT(a_result_held, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata), "result changed while stalled")

    // the engine is busy in the cycle after taking a request
    `BALE_ASSERT_NEXT(a_busy_after_take, i_s_axis_tvalid && o_s_axis_tready,
        !o_s_axis_tready, "request taken while the previous one was in progress")

    // a full status only comes with a full list
    `BALE_ASSERT_NOW(a_full_count, o_m_axis_tvalid && (res_status == bale_pkg::ST_FULL),
        res_count == bale_pkg::LCNT_W'(CAPACITY), "full status with room left")

    // failed operations report no locate position
    `BALE_ASSERT_NOW(a_fail_no_pos, o_m_axis_tvalid && (res_status != bale_pkg::ST_OK),
        res_fpos == '0, "locate position set on a failed request")

endmodule

bind bounded_array_list_engine bale_chk #(
    .CAPACITY (CAPACITY)
) u_bale_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

@@ test/tb_bounded_array_list_engine.sv @@
// self-checking testbench for the bounded array list engine: directed edge cases, a random
// mix of list operations with random idling on both streams, then traffic with no idling
// depends on bale_pkg and the bounded_array_list_engine rtl
module tb_bounded_array_list_engine;

    localparam int CAPACITY = 16;

    // command codes the engine treats as no-ops
    localparam logic [bale_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [bale_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    // one result as the engine should report it
    typedef struct packed {
        logic [bale_pkg::ST_W-1:0]   status;
        logic [bale_pkg::FPOS_W-1:0] found_pos;
        logic [bale_pkg::ID_W-1:0]   id;
        logic [bale_pkg::OAGE_W-1:0] age;
        logic [bale_pkg::LCNT_W-1:0] count;
    } t_list_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_ready;
    logic [bale_pkg::S_DATA_W-1:0] req_data = '0;
    logic [bale_pkg::CMD_W-1:0]    req_cmd = '0;
    logic                          res_valid;
    logic                          res_ready = 1'b1;
    logic [bale_pkg::M_DATA_W-1:0] res_data;

    // shadow copy of the list
    logic signed [bale_pkg::ID_W-1:0] list_ids [CAPACITY];
    logic [bale_pkg::AGE_W-1:0]       list_ages [CAPACITY];
    int                               list_len = 0;

    t_list_result pending_results [$];
    int  error_count = 0;
    int  sent_count = 0;
    int  result_count = 0;
    int  status_seen [5] = '{default: 0};
    int  longest_list = 0;
    bit  src_idle_on = 1'b1;
    bit  sink_idle_on = 1'b1;

    bounded_array_list_engine #(.CAPACITY(CAPACITY)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .i_s_axis_tuser  (req_cmd),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // insert into the shadow list, shifting the tail up
    function automatic logic [bale_pkg::ST_W-1:0] list_put(int pos,
                                                           logic [bale_pkg::ID_W-1:0] id,
                                                           logic [bale_pkg::AGE_W-1:0] age);
        if (list_len >= CAPACITY)
            return bale_pkg::ST_FULL;
        if (pos > list_len)
            return bale_pkg::ST_BADPOS;
        for (int i = list_len; i > pos; i--) begin
            list_ids[i]  = list_ids[i-1];
            list_ages[i] = list_ages[i-1];
        end
        list_ids[pos]  = id;
        list_ages[pos] = age;
        list_len++;
        return bale_pkg::ST_OK;
    endfunction

    // apply one request to the shadow list and work out its result
    function automatic t_list_result apply_list_op(logic [bale_pkg::CMD_W-1:0] cmd,
                                                   logic [bale_pkg::POS_W-1:0] pos,
                                                   logic [bale_pkg::ID_W-1:0] id,
                                                   logic [bale_pkg::AGE_W-1:0] age);
        t_list_result r;
        int slot;
        r = '0;
        r.status = bale_pkg::ST_OK;
        case (cmd)
            bale_pkg::CMD_INSERT: begin
                r.status = list_put(int'(pos), id, age);
            end
            bale_pkg::CMD_DELETE: begin
                if (list_len == 0) begin
                    r.status = bale_pkg::ST_EMPTY;
                end else if (int'(pos) >= list_len) begin
                    r.status = bale_pkg::ST_BADPOS;
                end else begin
                    for (int i = int'(pos); i + 1 < list_len; i++) begin
                        list_ids[i]  = list_ids[i+1];
                        list_ages[i] = list_ages[i+1];
                    end
                    list_len--;
                end
            end
            bale_pkg::CMD_LOCATE: begin
                r.status = bale_pkg::ST_NOTFOUND;
                for (int i = 0; i < list_len; i++) begin
                    if (list_ids[i] == id) begin
                        r.status    = bale_pkg::ST_OK;
                        r.found_pos = i[bale_pkg::FPOS_W-1:0];
                        break;
                    end
                end
            end
            bale_pkg::CMD_RETRIEVE: begin
                if (int'(pos) >= list_len) begin
                    r.status = bale_pkg::ST_BADPOS;
                    r.id     = '1;
                    r.age    = '1;
                end else begin
                    r.id  = list_ids[pos];
                    r.age = {1'b0, list_ages[pos]};
                end
            end
            bale_pkg::CMD_SORTED: begin
                if (list_len >= CAPACITY) begin
                    r.status = bale_pkg::ST_FULL;
                end else begin
                    slot = 0;
                    while (slot < list_len && list_ids[slot] < $signed(id))
                        slot++;
                    r.status = list_put(slot, id, age);
                end
            end
            bale_pkg::CMD_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        r.count = list_len[bale_pkg::LCNT_W-1:0];
        if (list_len > longest_list)
            longest_list = list_len;
        return r;
    endfunction

    // offer one request, wait for it to be taken, record what it should produce
    task automatic send_request(input logic [bale_pkg::CMD_W-1:0] cmd,
                                input logic [bale_pkg::POS_W-1:0] pos,
                                input logic [bale_pkg::ID_W-1:0] id,
                                input logic [bale_pkg::AGE_W-1:0] age);
        t_list_result want;
        begin
            req_valid <= 1'b1;
            req_cmd   <= cmd;
            req_data  <= {{(bale_pkg::S_DATA_W-bale_pkg::POS_W-bale_pkg::ID_W
                            -bale_pkg::AGE_W){1'b0}}, age, id, pos};
            @(posedge i_clk);
            while (!req_ready)
                @(posedge i_clk);
            want = apply_list_op(cmd, pos, id, age);
            pending_results.push_back(want);
            sent_count++;
            // random gap on the request side
            if (src_idle_on && $urandom_range(0, 5) == 0) begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    endtask

    // result side stalls in random bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (sink_idle_on && $urandom_range(0, 4) == 0) begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                res_ready <= 1'b1;
            end
        end
    end

    // compare each result with the oldest outstanding one
    always @(posedge i_clk) begin
        t_list_result want;
        t_list_result got;
        if (i_rst_n && res_valid && res_ready) begin
            got.status    = res_data[2:0];
            got.found_pos = res_data[6:3];
            got.id        = res_data[38:7];
            got.age       = res_data[47:39];
            got.count     = res_data[52:48];
            result_count++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (want.status <= bale_pkg::ST_NOTFOUND)
                    status_seen[want.status]++;
                if (got.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, got.status);
                    error_count++;
                end
                if (got.found_pos !== want.found_pos) begin
                    $display("%0t: found_position mismatch, expected %0d, got %0d",
                             $time, want.found_pos, got.found_pos);
                    error_count++;
                end
                if (got.id !== want.id) begin
                    $display("%0t: out_id mismatch, expected %h, got %h",
                             $time, want.id, got.id);
                    error_count++;
                end
                if (got.age !== want.age) begin
                    $display("%0t: out_age mismatch, expected %h, got %h",
                             $time, want.age, got.age);
                    error_count++;
                end
                if (got.count !== want.count) begin
                    $display("%0t: list_count mismatch, expected %0d, got %0d",
                             $time, want.count, got.count);
                    error_count++;
                end
            end
        end
    end

    // ids cluster on a few small values so duplicates and hits are common
    function automatic logic [bale_pkg::ID_W-1:0] pick_id();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            default: return $unsigned(int'($urandom_range(0, 8)) - 4);
        endcase
    endfunction

    // operations on an empty list
    task automatic test_empty_list_errors();
        send_request(bale_pkg::CMD_RETRIEVE, 5'd0, 32'h0, 8'h0);
        send_request(bale_pkg::CMD_DELETE, 5'd0, 32'h0, 8'h0);
        send_request(bale_pkg::CMD_LOCATE, 5'd0, 32'h0, 8'h0);
        send_request(bale_pkg::CMD_INSERT, 5'd1, 32'h1234_5678, 8'h12);
    endtask

    // fill to capacity with extreme ids and ages, then push past it
    task automatic test_fill_and_overflow();
        send_request(bale_pkg::CMD_INSERT, 5'd0, 32'h7fff_ffff, 8'hff);
        send_request(bale_pkg::CMD_INSERT, 5'd0, 32'h8000_0000, 8'h00);
        send_request(bale_pkg::CMD_INSERT, 5'd2, 32'd5, 8'h01);
        send_request(bale_pkg::CMD_SORTED, 5'd0, 32'd5, 8'h02);
        send_request(bale_pkg::CMD_SORTED, 5'd0, 32'hffff_ffff, 8'h03);
        send_request(bale_pkg::CMD_SORTED, 5'd0, 32'h7fff_ffff, 8'h04);
        send_request(bale_pkg::CMD_SORTED, 5'd0, 32'h8000_0000, 8'h05);
        while (list_len < CAPACITY)
            send_request(bale_pkg::CMD_INSERT, 5'(list_len / 2), 32'(list_len * 1000),
                         8'(list_len * 17));
        send_request(bale_pkg::CMD_INSERT, 5'd0, 32'd9, 8'h09);
        send_request(bale_pkg::CMD_SORTED, 5'd0, 32'd9, 8'h09);
        send_request(bale_pkg::CMD_RETRIEVE, 5'd15, 32'h0, 8'h0);
        send_request(bale_pkg::CMD_LOCATE, 5'd0, list_ids[CAPACITY-1], 8'h0);
    endtask

    // bad positions at the list end, spare commands, clear
    task automatic test_edges_and_clear();
        send_request(bale_pkg::CMD_DELETE, 5'd16, 32'h0, 8'h0);
        send_request(bale_pkg::CMD_RETRIEVE, 5'd31, 32'h0, 8'h0);
        send_request(bale_pkg::CMD_DELETE, 5'd15, 32'h0, 8'h0);
        send_request(bale_pkg::CMD_INSERT, 5'(list_len + 1), 32'd7, 8'h07);
        send_request(CMD_SPARE_6, 5'd3, 32'hdead_beef, 8'haa);
        send_request(CMD_SPARE_7, 5'd31, 32'hffff_ffff, 8'hff);
        send_request(bale_pkg::CMD_CLEAR, 5'd0, 32'h0, 8'h0);
        send_request(bale_pkg::CMD_RETRIEVE, 5'd0, 32'h0, 8'h0);
    endtask

    // random mix of operations, idling switched per chunk
    task automatic test_random_ops(input int n_items);
        int roll;
        logic [bale_pkg::CMD_W-1:0] cmd;
        logic [bale_pkg::POS_W-1:0] pos;
        logic [bale_pkg::ID_W-1:0]  id;
        for (int k = 0; k < n_items; k++) begin
            if (k % 100 == 0) begin
                src_idle_on  = ($urandom_range(0, 3) != 0);
                sink_idle_on = ($urandom_range(0, 3) != 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 22)
                cmd = bale_pkg::CMD_INSERT;
            else if (roll < 40)
                cmd = bale_pkg::CMD_DELETE;
            else if (roll < 55)
                cmd = bale_pkg::CMD_LOCATE;
            else if (roll < 72)
                cmd = bale_pkg::CMD_RETRIEVE;
            else if (roll < 92)
                cmd = bale_pkg::CMD_SORTED;
            else if (roll < 95)
                cmd = bale_pkg::CMD_CLEAR;
            else
                cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
            // mostly legal positions, some anywhere in the field
            if ($urandom_range(0, 9) < 8)
                pos = 5'($urandom_range(0, list_len));
            else
                pos = 5'($urandom_range(0, 31));
            if (cmd == bale_pkg::CMD_LOCATE && list_len > 0 && $urandom_range(0, 1))
                id = list_ids[$urandom_range(0, list_len - 1)];
            else
                id = pick_id();
            send_request(cmd, pos, id, 8'($urandom_range(0, 255)));
        end
    endtask

    // back-to-back traffic with no idling at all
    task automatic test_steady_stream(input int n_items);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        for (int k = 0; k < n_items; k++)
            send_request(3'($urandom_range(0, 5)), 5'($urandom_range(0, list_len)),
                         pick_id(), 8'($urandom_range(0, 255)));
    endtask

    // main sequence
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_list_errors();
        test_fill_and_overflow();
        test_edges_and_clear();
        test_random_ops(1600);
        test_steady_stream(300);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (48) @(posedge i_clk);
        $display("covered %0d requests and %0d results, longest list %0d entries",
                 sent_count, result_count, longest_list);
        $display("status ok %0d, full %0d, bad position %0d, empty %0d, not found %0d",
                 status_seen[bale_pkg::ST_OK], status_seen[bale_pkg::ST_FULL],
                 status_seen[bale_pkg::ST_BADPOS], status_seen[bale_pkg::ST_EMPTY],
                 status_seen[bale_pkg::ST_NOTFOUND]);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
